/* rtl/qyh_pkg.sv */
// shared constants and the cordic arctangent table for the quaternion yaw heading block
package qyh_pkg;

  // input sample width, signed q2.14
  localparam int QW     = 16;
  // 16x16 signed product
  localparam int PW     = 32;
  // rotation-matrix terms, exact q6.28
  localparam int RW     = 34;
  // cordic x/y datapath, covers the cordic gain on the largest vector
  localparam int CW     = 36;
  // angle accumulator in 2^-20 degree
  localparam int ZW     = 30;
  localparam int ZFRAC  = 20;
  // z * 100 before rounding back to centidegrees
  localparam int MW     = 38;
  // heading sum and wrap arithmetic
  localparam int HW     = MW - ZFRAC;
  // correction register width
  localparam int CORRW  = 9;
  localparam int OUTW   = 16;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int ATAN_LEN     = 24;
  localparam int FULL_TURN_CD = 36000;
  localparam int HALF_TURN_Z  = 180 * (2 ** ZFRAC);
  localparam int ONE_Q28      = 2 ** 28;

  // register index of the mounting correction
  localparam logic REG_MOUNT_CORR = 1'b0;

  // atan(2^-i) in degrees times 2^20, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q20(input int idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      0:       val = ZW'(47185920);
      1:       val = ZW'(27855475);
      2:       val = ZW'(14718068);
      3:       val = ZW'(7471121);
      4:       val = ZW'(3750058);
      5:       val = ZW'(1876857);
      6:       val = ZW'(938658);
      7:       val = ZW'(469357);
      8:       val = ZW'(234682);
      9:       val = ZW'(117342);
      10:      val = ZW'(58671);
      11:      val = ZW'(29335);
      12:      val = ZW'(14668);
      13:      val = ZW'(7334);
      14:      val = ZW'(3667);
      15:      val = ZW'(1833);
      16:      val = ZW'(917);
      17:      val = ZW'(458);
      18:      val = ZW'(229);
      19:      val = ZW'(115);
      20:      val = ZW'(57);
      21:      val = ZW'(29);
      22:      val = ZW'(14);
      23:      val = ZW'(7);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/quaternion_yaw_heading.sv */
// quaternion to compass heading, fully pipelined cordic with mounting correction
//
// usage
//   input channel: drive quat_real_i/quat_i_i/quat_j_i/quat_k_i (signed q2.14) and
//   raise start; the item transfers at every rising edge where start is high and
//   busy is low. busy is tied low, so a new quaternion can transfer every cycle.
//   result channel: done_o is high for exactly one cycle with heading_centideg_o
//   (0..35999, hundredths of a degree); the result transfers at the edge ending
//   that cycle. the receiver cannot stall, so nothing in the pipe ever waits.
//   config: apb port, mount_correction_deg at byte address 0 (signed 9 bits,
//   whole degrees); write it only while no item is in flight.
// timing
//   from the input transfer edge to the result transfer edge the item passes the
//   registers in this order (steps capped at 24): product stage, matrix-term
//   stage, quadrant stage, one stage per cordic iteration, scale stage,
//   correction stage, wrap/output register. throughput is one item per cycle.
// reset
//   rst_ni clears all valid bits and sets the correction to zero; items in
//   flight are dropped.
module quaternion_yaw_heading
  import qyh_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [QW-1:0]     quat_real_i,
  input  logic signed [QW-1:0]     quat_i_i,
  input  logic signed [QW-1:0]     quat_j_i,
  input  logic signed [QW-1:0]     quat_k_i,
  // result channel
  output logic                     done_o,
  output logic        [OUTW-1:0]   heading_centideg_o,
  // apb config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [APB_AW-1:0] paddr,
  input  logic        [APB_DW-1:0] pwdata,
  output logic        [APB_DW-1:0] prdata,
  output logic                     pready
);

  // iterations actually run; the table stops at 24 entries
  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // config register
  // ---------------------------------------------------------------------------
  logic signed [CORRW-1:0] corr_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MOUNT_CORR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= '0;
    end else if (cfg_wr) begin
      corr_q <= pwdata[CORRW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_MOUNT_CORR) begin
      prdata = {{(APB_DW-CORRW){corr_q[CORRW-1]}}, corr_q};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // stage p: the four products
  // ---------------------------------------------------------------------------
  logic                 p_vld_q;
  logic signed [PW-1:0] pjj_q, pkk_q, pij_q, prk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    pjj_q <= PW'(quat_j_i * quat_j_i);
    pkk_q <= PW'(quat_k_i * quat_k_i);
    pij_q <= PW'(quat_i_i * quat_j_i);
    prk_q <= PW'(quat_real_i * quat_k_i);
  end

  // ---------------------------------------------------------------------------
  // stage r: r11 = 1 - 2(jj + kk), r21 = 2(ij + rk), exact q6.28
  // ---------------------------------------------------------------------------
  logic                 r_vld_q;
  logic signed [RW-1:0] r11_d, r21_d, r11_q, r21_q;
  logic signed [RW-1:0] sq_sum, cr_sum;

  always_comb begin
    sq_sum = RW'(pjj_q) + RW'(pkk_q);
    cr_sum = RW'(pij_q) + RW'(prk_q);
    r11_d  = RW'(ONE_Q28) - (sq_sum <<< 1);
    r21_d  = cr_sum <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r11_q <= r11_d;
    r21_q <= r21_d;
  end

  // ---------------------------------------------------------------------------
  // stage q and cordic chain; index 0 is the quadrant-corrected start vector
  // ---------------------------------------------------------------------------
  logic                 cv_q  [NSTEPS+1];
  logic                 czf_q [NSTEPS+1];
  logic signed [CW-1:0] cx_q  [NSTEPS+1];
  logic signed [CW-1:0] cy_q  [NSTEPS+1];
  logic signed [ZW-1:0] cz_q  [NSTEPS+1];

  logic signed [CW-1:0] q_x_d, q_y_d;
  logic signed [ZW-1:0] q_z_d;
  logic                 q_zf_d;

  // atan2(-r21, r11): left half plane is folded over with a 180 degree start
  always_comb begin
    q_zf_d = (r11_q == '0) && (r21_q == '0);
    if (r11_q[RW-1]) begin
      q_x_d = -CW'(r11_q);
      q_y_d = CW'(r21_q);
      // original y = -r21 >= 0 picks +180
      q_z_d = (r21_q[RW-1] || (r21_q == '0)) ? ZW'(HALF_TURN_Z) : -ZW'(HALF_TURN_Z);
    end else begin
      q_x_d = CW'(r11_q);
      q_y_d = -CW'(r21_q);
      q_z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0]  <= q_x_d;
    cy_q[0]  <= q_y_d;
    cz_q[0]  <= q_z_d;
    czf_q[0] <= q_zf_d;
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN_K = atan_q20(k);

    logic signed [CW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_d;
    logic                 y_pos;

    always_comb begin
      xs    = cx_q[k] >>> k;
      ys    = cy_q[k] >>> k;
      y_pos = !cy_q[k][CW-1] && (cy_q[k] != '0);
      if (y_pos) begin
        x_d = cx_q[k] + ys;
        y_d = cy_q[k] - xs;
        z_d = cz_q[k] + ATAN_K;
      end else begin
        x_d = cx_q[k] - ys;
        y_d = cy_q[k] + xs;
        z_d = cz_q[k] - ATAN_K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      cx_q[k+1]  <= x_d;
      cy_q[k+1]  <= y_d;
      cz_q[k+1]  <= z_d;
      czf_q[k+1] <= czf_q[k];
    end
  end

  // ---------------------------------------------------------------------------
  // stage m: centidegrees = floor((z * 100 + 2^19) / 2^20); zero vector gives 0
  // ---------------------------------------------------------------------------
  logic                 m_vld_q;
  logic signed [HW-1:0] yaw_q;
  logic signed [MW-1:0] zx, zscaled;

  always_comb begin
    zx      = czf_q[NSTEPS] ? '0 : MW'(cz_q[NSTEPS]);
    zscaled = (zx <<< 6) + (zx <<< 5) + (zx <<< 2) + MW'(2 ** (ZFRAC - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= cv_q[NSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q <= zscaled[MW-1:ZFRAC];
  end

  // ---------------------------------------------------------------------------
  // stage h: add correction * 100
  // ---------------------------------------------------------------------------
  logic                 h_vld_q;
  logic signed [HW-1:0] h_q, corr_ext, corr_cd;

  always_comb begin
    corr_ext = HW'(corr_q);
    corr_cd  = (corr_ext <<< 6) + (corr_ext <<< 5) + (corr_ext <<< 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= yaw_q + corr_cd;
  end

  // ---------------------------------------------------------------------------
  // stage w: wrap into 0..35999 and output register
  // sum stays within +-43600, so at most two turns are added or one removed
  // ---------------------------------------------------------------------------
  localparam logic signed [HW-1:0] TURN = HW'(FULL_TURN_CD);

  logic signed [HW-1:0] wrap_d;
  logic                 done_q;
  logic [OUTW-1:0]      heading_q;

  always_comb begin
    priority if (h_q < -TURN) begin
      wrap_d = h_q + (TURN <<< 1);
    end else if (h_q[HW-1]) begin
      wrap_d = h_q + TURN;
    end else if (h_q >= TURN) begin
      wrap_d = h_q - TURN;
    end else begin
      wrap_d = h_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q <= wrap_d[OUTW-1:0];
  end

  assign done_o             = done_q;
  assign heading_centideg_o = heading_q;

endmodule

/* rtl/qyh_checker.sv */
// port-level checker for the quaternion yaw heading block and its bind
module qyh_checker
  import qyh_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     done_o,
  input logic        [OUTW-1:0]   heading_centideg_o,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic        [APB_AW-1:0] paddr,
  input logic        [APB_DW-1:0] pwdata,
  input logic        [APB_DW-1:0] prdata
);

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int LAT    = NSTEPS + 6;
  localparam int CNTW   = $clog2(LAT + 1);

  logic            accept;
  logic [CNTW-1:0] up_cnt_q;

  assign accept = start && !busy;

  // cycles since reset release, saturating at the pipeline latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_cnt_q <= '0;
    end else if (up_cnt_q != CNTW'(LAT)) begin
      up_cnt_q <= up_cnt_q + 1'b1;
    end
  end

  // every result stems from the input transfer a pipeline latency earlier
  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result without matching input transfer");

  // no transfer is lost once the pipe has run clear of reset
  a_no_lost_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_cnt_q == CNTW'(LAT)) && $past(accept, LAT) |-> done_o)
    else $error("input transfer produced no result");

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_centideg_o < OUTW'(FULL_TURN_CD)))
    else $error("heading outside 0..35999");

  a_cfg_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_MOUNT_CORR)
    |=> paddr[2] || (prdata[CORRW-1:0] == $past(pwdata[CORRW-1:0])))
    else $error("correction register readback mismatch");

endmodule

bind quaternion_yaw_heading qyh_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_qyh_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .done_o             (done_o),
  .heading_centideg_o (heading_centideg_o),
  .psel               (psel),
  .penable            (penable),
  .pwrite             (pwrite),
  .paddr              (paddr),
  .pwdata             (pwdata),
  .prdata             (prdata)
);
